[hw/rtl/tcc_pkg.sv]
// Shared types, constants, tables and control store of the calendar converter.
`default_nettype none

package tcc_pkg;

  // Chip year that starts the epoch.
  localparam logic [7:0] YEAR_OFFSET = 8'd2;

  localparam int ACC_W   = 34;   // holds any fields-to-seconds sum without wrapping
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PC_W    = 4;

  localparam logic [ACC_W-1:0] DAY_SECS       = 34'd86400;
  localparam logic [ACC_W-1:0] HOUR_SECS      = 34'd3600;
  localparam logic [ACC_W-1:0] MIN_SECS       = 34'd60;
  localparam logic [ACC_W-1:0] MAX_SECS       = 34'd2147483647;
  localparam logic [ACC_W-1:0] YEAR_SECS      = 34'd31536000;
  localparam logic [ACC_W-1:0] YEAR_LEAP_SECS = 34'd31622400;
  localparam logic [ACC_W-1:0] MON31_SECS     = 34'd2678400;
  localparam logic [ACC_W-1:0] MON30_SECS     = 34'd2592000;
  localparam logic [ACC_W-1:0] FEB_SECS       = 34'd2419200;
  localparam logic [ACC_W-1:0] FEB_LEAP_SECS  = 34'd2505600;

  // Multiplier constants. The last is ceil(2^32 / 10000): the high bits of
  // the product give microseconds / 10000 exactly over the 20-bit range.
  localparam logic [MUL_B_W-1:0] MB_DAY   = 19'd86400;
  localparam logic [MUL_B_W-1:0] MB_HOUR  = 19'd3600;
  localparam logic [MUL_B_W-1:0] MB_MIN   = 19'd60;
  localparam logic [MUL_B_W-1:0] MB_HS    = 19'd10000;
  localparam logic [MUL_B_W-1:0] MB_RECIP = 19'd429497;

  // Datapath operations.
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_INIT0    = 4'd1;
  localparam logic [3:0] OP_ADD_YEAR = 4'd2;
  localparam logic [3:0] OP_ADD_MON  = 4'd3;
  localparam logic [3:0] OP_INIT1    = 4'd4;
  localparam logic [3:0] OP_SUB_YEAR = 4'd5;
  localparam logic [3:0] OP_SUB_MON  = 4'd6;
  localparam logic [3:0] OP_SUB_DAY  = 4'd7;
  localparam logic [3:0] OP_SUB_HR   = 4'd8;
  localparam logic [3:0] OP_SUB_MIN  = 4'd9;
  localparam logic [3:0] OP_FIN0     = 4'd10;
  localparam logic [3:0] OP_FIN1     = 4'd11;
  localparam logic [3:0] OP_FIN_BAD  = 4'd12;

  // Multiplier operand selection.
  localparam logic [2:0] M_NONE = 3'd0;
  localparam logic [2:0] M_DAY  = 3'd1;
  localparam logic [2:0] M_HR   = 3'd2;
  localparam logic [2:0] M_MIN  = 3'd3;
  localparam logic [2:0] M_HS   = 3'd4;
  localparam logic [2:0] M_US   = 3'd5;

  // Jump conditions.
  localparam logic [3:0] C_NONE     = 4'd0;
  localparam logic [3:0] C_BAD      = 4'd1;
  localparam logic [3:0] C_YR_DONE  = 4'd2;
  localparam logic [3:0] C_MON_DONE = 4'd3;
  localparam logic [3:0] C_YR_LT    = 4'd4;
  localparam logic [3:0] C_MON_STOP = 4'd5;
  localparam logic [3:0] C_LT_DAY   = 4'd6;
  localparam logic [3:0] C_LT_HR    = 4'd7;
  localparam logic [3:0] C_LT_MIN   = 4'd8;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_F0_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_F0_YEAR = 4'd1;
  localparam logic [PC_W-1:0] PC_F0_MON  = 4'd2;
  localparam logic [PC_W-1:0] PC_F0_DAY  = 4'd3;
  localparam logic [PC_W-1:0] PC_F0_HR   = 4'd4;
  localparam logic [PC_W-1:0] PC_F0_MIN  = 4'd5;
  localparam logic [PC_W-1:0] PC_F0_FIN  = 4'd6;
  localparam logic [PC_W-1:0] PC_BAD     = 4'd7;
  localparam logic [PC_W-1:0] PC_F1_INIT = 4'd8;
  localparam logic [PC_W-1:0] PC_F1_YEAR = 4'd9;
  localparam logic [PC_W-1:0] PC_F1_MON  = 4'd10;
  localparam logic [PC_W-1:0] PC_F1_DAY  = 4'd11;
  localparam logic [PC_W-1:0] PC_F1_HR   = 4'd12;
  localparam logic [PC_W-1:0] PC_F1_MIN  = 4'd13;
  localparam logic [PC_W-1:0] PC_F1_FIN  = 4'd14;
  localparam logic [PC_W-1:0] PC_LAST    = PC_F1_FIN;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      msel;
    logic            pacc;   // add the registered product into the accumulator
    logic [3:0]      cond;
    logic [PC_W-1:0] tgt;
    logic            hold;   // repeat this step until its condition holds
    logic            done;   // load the result register and end the program
  } uword_t;

  typedef struct packed {
    logic       en;
    logic [3:0] op;
    logic [2:0] msel;
    logic       pacc;
    logic       done;
  } dp_ctrl_t;

  typedef struct packed {
    logic bad;
    logic yr_done;
    logic mon_done;
    logic yr_lt;
    logic mon_stop;
    logic lt_day;
    logic lt_hr;
    logic lt_min;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0]  chip_year;
    logic [7:0]  month_in;
    logic [7:0]  day_in;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic [7:0]  second_in;
    logic [6:0]  hundredths_in;
    logic [7:0]  weekday_in;
    logic [30:0] epoch_seconds;
    logic [19:0] microseconds;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [30:0] seconds_out;
    logic [19:0] micro_out;
    logic [7:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [6:0]  hundredths_out;
    logic [2:0]  weekday_out;
  } res_t;

  function automatic logic [ACC_W-1:0] year_secs(input logic [7:0] yr);
    return (yr[1:0] == 2'b00) ? YEAR_LEAP_SECS : YEAR_SECS;
  endfunction

  function automatic logic [ACC_W-1:0] month_secs(input logic [3:0] mon, input logic leap);
    logic [ACC_W-1:0] r;
    unique case (mon)
      4'd2:                      r = leap ? FEB_LEAP_SECS : FEB_SECS;
      4'd4, 4'd6, 4'd9, 4'd11:   r = MON30_SECS;
      default:                   r = MON31_SECS;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mod7(input logic [4:0] d);
    logic [4:0] v;
    v = d;
    if (v >= 5'd28) v = v - 5'd28;
    if (v >= 5'd14) v = v - 5'd14;
    if (v >= 5'd7)  v = v - 5'd7;
    return v[2:0];
  endfunction

  // Control store. Fields to seconds starts at PC_F0_INIT, seconds to fields
  // at PC_F1_INIT.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      PC_F0_INIT: begin
        w.op = OP_INIT0; w.msel = M_DAY; w.cond = C_BAD; w.tgt = PC_BAD;
      end
      PC_F0_YEAR: begin
        w.op = OP_ADD_YEAR; w.cond = C_YR_DONE; w.tgt = PC_F0_MON; w.hold = 1'b1;
      end
      PC_F0_MON: begin
        w.op = OP_ADD_MON; w.cond = C_MON_DONE; w.tgt = PC_F0_DAY; w.hold = 1'b1;
      end
      PC_F0_DAY:  begin w.pacc = 1'b1; w.msel = M_HR;  end
      PC_F0_HR:   begin w.pacc = 1'b1; w.msel = M_MIN; end
      PC_F0_MIN:  begin w.pacc = 1'b1; w.msel = M_HS;  end
      PC_F0_FIN:  begin w.op = OP_FIN0; w.done = 1'b1; end
      PC_BAD:     begin w.op = OP_FIN_BAD; w.done = 1'b1; end
      PC_F1_INIT: begin w.op = OP_INIT1; w.msel = M_US; end
      PC_F1_YEAR: begin
        w.op = OP_SUB_YEAR; w.cond = C_YR_LT; w.tgt = PC_F1_MON; w.hold = 1'b1;
      end
      PC_F1_MON: begin
        w.op = OP_SUB_MON; w.cond = C_MON_STOP; w.tgt = PC_F1_DAY; w.hold = 1'b1;
      end
      PC_F1_DAY: begin
        w.op = OP_SUB_DAY; w.cond = C_LT_DAY; w.tgt = PC_F1_HR; w.hold = 1'b1;
      end
      PC_F1_HR: begin
        w.op = OP_SUB_HR; w.cond = C_LT_HR; w.tgt = PC_F1_MIN; w.hold = 1'b1;
      end
      PC_F1_MIN: begin
        w.op = OP_SUB_MIN; w.cond = C_LT_MIN; w.tgt = PC_F1_FIN; w.hold = 1'b1;
      end
      PC_F1_FIN:  begin w.op = OP_FIN1; w.done = 1'b1; end
      default:    begin w.op = OP_FIN_BAD; w.done = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcc_sequencer.sv]
// Microcode sequencer: step counter, control store read and conditional jumps.
`default_nettype none

module tcc_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               func,
  input  wire logic               out_free,
  input  wire tcc_pkg::dp_stat_t  stat,
  output logic                    busy,
  output tcc_pkg::dp_ctrl_t       ctrl
);

  logic                     busy_r, busy_nxt;
  logic [tcc_pkg::PC_W-1:0] pc_r, pc_nxt;
  tcc_pkg::uword_t          uw;
  logic                     cond_hit;

  assign uw   = tcc_pkg::ucode(pc_r);
  assign busy = busy_r;

  always_comb begin
    unique case (uw.cond)
      tcc_pkg::C_NONE:     cond_hit = 1'b0;
      tcc_pkg::C_BAD:      cond_hit = stat.bad;
      tcc_pkg::C_YR_DONE:  cond_hit = stat.yr_done;
      tcc_pkg::C_MON_DONE: cond_hit = stat.mon_done;
      tcc_pkg::C_YR_LT:    cond_hit = stat.yr_lt;
      tcc_pkg::C_MON_STOP: cond_hit = stat.mon_stop;
      tcc_pkg::C_LT_DAY:   cond_hit = stat.lt_day;
      tcc_pkg::C_LT_HR:    cond_hit = stat.lt_hr;
      tcc_pkg::C_LT_MIN:   cond_hit = stat.lt_min;
      default:             cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    ctrl.en   = 1'b0;
    ctrl.op   = uw.op;
    ctrl.msel = uw.msel;
    ctrl.pacc = uw.pacc;
    ctrl.done = uw.done;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = func ? tcc_pkg::PC_F1_INIT : tcc_pkg::PC_F0_INIT;
      end
    end else if (uw.done) begin
      // The last step waits until the result register can take the result.
      if (out_free) begin
        ctrl.en  = 1'b1;
        busy_nxt = 1'b0;
      end
    end else if (cond_hit) begin
      pc_nxt = uw.tgt;
    end else begin
      ctrl.en = 1'b1;
      if (!uw.hold) pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= tcc_pkg::PC_F0_INIT;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= tcc_pkg::PC_LAST)
    else $error("step counter left the program");

  a_finish_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uw.done && out_free) |=> !busy_r)
    else $error("program did not end after its last step");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("item started while a program runs");

endmodule

`default_nettype wire

[hw/rtl/tcc_datapath.sv]
// Datapath: accumulator, year/month/time counters, shared multiplier, result register.
`default_nettype none

module tcc_datapath (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire tcc_pkg::in_item_t item,
  input  wire tcc_pkg::dp_ctrl_t ctrl,
  output tcc_pkg::dp_stat_t      stat,
  output tcc_pkg::res_t          res
);

  tcc_pkg::in_item_t           item_r;
  logic [tcc_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [tcc_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [7:0]                  yr_r, yr_nxt;
  logic [3:0]                  mon_r, mon_nxt;
  logic [4:0]                  dcnt_r, dcnt_nxt;
  logic [4:0]                  hcnt_r, hcnt_nxt;
  logic [5:0]                  mcnt_r, mcnt_nxt;
  tcc_pkg::res_t               res_r, res_nxt;

  logic [tcc_pkg::MUL_A_W-1:0] mul_a;
  logic [tcc_pkg::MUL_B_W-1:0] mul_b;
  logic [4:0]                  day_m1;
  logic [tcc_pkg::ACC_W-1:0]   ysecs, msecs;
  logic [6:0]                  hs_q;
  logic [4:0]                  day_val;
  logic                        fields_ok;

  assign ysecs   = tcc_pkg::year_secs(yr_r);
  assign msecs   = tcc_pkg::month_secs(mon_r, yr_r[1:0] == 2'b00);
  assign day_m1  = item_r.day_in[4:0] - 5'd1;
  assign hs_q    = prod_r[tcc_pkg::PROD_W-1:32];
  assign day_val = dcnt_r + 5'd1;
  assign res     = res_r;

  assign fields_ok = (item_r.month_in >= 8'd1) && (item_r.month_in <= 8'd12) &&
                     (item_r.day_in >= 8'd1) && (item_r.day_in <= 8'd31) &&
                     (item_r.weekday_in <= 8'd6) && (item_r.hour_in <= 8'd23) &&
                     (item_r.minute_in <= 8'd59) && (item_r.second_in <= 8'd59) &&
                     (item_r.hundredths_in <= 7'd99) &&
                     (item_r.chip_year >= tcc_pkg::YEAR_OFFSET);

  always_comb begin
    stat.bad      = !fields_ok;
    stat.yr_done  = yr_r >= item_r.chip_year;
    stat.mon_done = {4'b0, mon_r} >= item_r.month_in;
    stat.yr_lt    = acc_r < ysecs;
    stat.mon_stop = (mon_r == 4'd12) || (acc_r < msecs);
    stat.lt_day   = acc_r < tcc_pkg::DAY_SECS;
    stat.lt_hr    = acc_r < tcc_pkg::HOUR_SECS;
    stat.lt_min   = acc_r < tcc_pkg::MIN_SECS;
  end

  always_comb begin
    unique case (ctrl.msel)
      tcc_pkg::M_DAY: begin mul_a = {15'b0, day_m1};          mul_b = tcc_pkg::MB_DAY;   end
      tcc_pkg::M_HR:  begin mul_a = {12'b0, item_r.hour_in};   mul_b = tcc_pkg::MB_HOUR;  end
      tcc_pkg::M_MIN: begin mul_a = {12'b0, item_r.minute_in}; mul_b = tcc_pkg::MB_MIN;   end
      tcc_pkg::M_HS:  begin
        mul_a = {13'b0, item_r.hundredths_in};
        mul_b = tcc_pkg::MB_HS;
      end
      tcc_pkg::M_US:  begin mul_a = item_r.microseconds;       mul_b = tcc_pkg::MB_RECIP; end
      default:        begin mul_a = '0;                        mul_b = '0;                end
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    yr_nxt   = yr_r;
    mon_nxt  = mon_r;
    dcnt_nxt = dcnt_r;
    hcnt_nxt = hcnt_r;
    mcnt_nxt = mcnt_r;
    res_nxt  = res_r;
    if (ctrl.en) begin
      if (ctrl.msel != tcc_pkg::M_NONE) prod_nxt = mul_a * mul_b;
      if (ctrl.pacc) acc_nxt = acc_r + prod_r[tcc_pkg::ACC_W-1:0];
      unique case (ctrl.op)
        tcc_pkg::OP_NOP: ;
        tcc_pkg::OP_INIT0: begin
          // Seconds go in first so the last add step is not needed.
          acc_nxt = {26'b0, item_r.second_in};
          yr_nxt  = tcc_pkg::YEAR_OFFSET;
          mon_nxt = 4'd1;
        end
        tcc_pkg::OP_ADD_YEAR: begin
          acc_nxt = acc_r + ysecs;
          yr_nxt  = yr_r + 8'd1;
        end
        tcc_pkg::OP_ADD_MON: begin
          acc_nxt = acc_r + msecs;
          mon_nxt = mon_r + 4'd1;
        end
        tcc_pkg::OP_INIT1: begin
          acc_nxt  = {3'b0, item_r.epoch_seconds};
          yr_nxt   = tcc_pkg::YEAR_OFFSET;
          mon_nxt  = 4'd1;
          dcnt_nxt = '0;
          hcnt_nxt = '0;
          mcnt_nxt = '0;
        end
        tcc_pkg::OP_SUB_YEAR: begin
          acc_nxt = acc_r - ysecs;
          yr_nxt  = yr_r + 8'd1;
        end
        tcc_pkg::OP_SUB_MON: begin
          acc_nxt = acc_r - msecs;
          mon_nxt = mon_r + 4'd1;
        end
        tcc_pkg::OP_SUB_DAY: begin
          acc_nxt  = acc_r - tcc_pkg::DAY_SECS;
          dcnt_nxt = dcnt_r + 5'd1;
        end
        tcc_pkg::OP_SUB_HR: begin
          acc_nxt  = acc_r - tcc_pkg::HOUR_SECS;
          hcnt_nxt = hcnt_r + 5'd1;
        end
        tcc_pkg::OP_SUB_MIN: begin
          acc_nxt  = acc_r - tcc_pkg::MIN_SECS;
          mcnt_nxt = mcnt_r + 6'd1;
        end
        tcc_pkg::OP_FIN0: begin
          res_nxt = '0;
          if (acc_r <= tcc_pkg::MAX_SECS) begin
            res_nxt.valid_res   = 1'b1;
            res_nxt.seconds_out = acc_r[30:0];
            res_nxt.micro_out   = prod_r[19:0];
          end
        end
        tcc_pkg::OP_FIN1: begin
          res_nxt                = '0;
          res_nxt.valid_res      = 1'b1;
          res_nxt.year_out       = yr_r;
          res_nxt.month_out      = mon_r;
          res_nxt.day_out        = day_val;
          res_nxt.hour_out       = hcnt_r;
          res_nxt.minute_out     = mcnt_r;
          res_nxt.second_out     = acc_r[5:0];
          res_nxt.hundredths_out = (hs_q > 7'd99) ? 7'd99 : hs_q;
          res_nxt.weekday_out    = tcc_pkg::mod7(day_val);
        end
        tcc_pkg::OP_FIN_BAD: res_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) item_r <= item;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    yr_r   <= yr_nxt;
    mon_r  <= mon_nxt;
    dcnt_r <= dcnt_nxt;
    hcnt_r <= hcnt_nxt;
    mcnt_r <= mcnt_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/tod_calendar_converter.sv]
// Top level of the calendar converter: stream ports, result handshake, sequencer and datapath.
//
// Converts real-time-clock calendar fields to seconds since the epoch (in_tuser = 0)
// or seconds and microseconds back to calendar fields (in_tuser = 1).
// One input transaction gives exactly one output transaction, in order.
// The block works on one item at a time: in_tready is high while no program runs.
// A microcoded sequencer drives one add/subtract accumulator and one shared
// multiplier; years and months are stepped one at a time, and when converting seconds
// to fields so are days, hours and minutes, the remaining time being walked down by
// whole units. A new item can be accepted in the cycle after a result is loaded;
// the block never takes a new item before it is through with the last one.
// The result sits in an output register; if out_tready is low the next item may
// still be accepted and run, but its final step waits until the register empties.
// Synchronous active-low reset clears the sequencer and drops out_tvalid.
`default_nettype none

module tod_calendar_converter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // chip_year[7:0], month_in[15:8], day_in[23:16], hour_in[31:24], minute_in[39:32],
  // second_in[47:40], hundredths_in[54:48], weekday_in[62:55],
  // epoch_seconds[93:63], microseconds[113:94], zero padding[119:114]
  input  wire logic [119:0] in_tdata,
  // func[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // seconds_out[30:0], micro_out[50:31], year_out[58:51], month_out[62:59],
  // day_out[67:63], hour_out[72:68], minute_out[78:73], second_out[84:79],
  // hundredths_out[91:85], weekday_out[94:92], zero padding[95]
  output logic [95:0]       out_tdata,
  // valid_res[0]
  output logic              out_tuser
);

  tcc_pkg::in_item_t item;
  tcc_pkg::res_t     res;
  tcc_pkg::dp_ctrl_t ctrl;
  tcc_pkg::dp_stat_t stat;
  logic              busy, in_fire, out_free, fin_fire;
  logic              out_valid_r, out_valid_nxt;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_fire  = ctrl.en && ctrl.done;

  always_comb begin
    item.chip_year     = in_tdata[7:0];
    item.month_in      = in_tdata[15:8];
    item.day_in        = in_tdata[23:16];
    item.hour_in       = in_tdata[31:24];
    item.minute_in     = in_tdata[39:32];
    item.second_in     = in_tdata[47:40];
    item.hundredths_in = in_tdata[54:48];
    item.weekday_in    = in_tdata[62:55];
    item.epoch_seconds = in_tdata[93:63];
    item.microseconds  = in_tdata[113:94];
  end

  tcc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .func     (in_tuser),
    .out_free (out_free),
    .stat     (stat),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  tcc_datapath u_dp (
    .clk   (clk),
    .start (in_fire),
    .item  (item),
    .ctrl  (ctrl),
    .stat  (stat),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (fin_fire)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res.valid_res;
  assign out_tdata  = {1'b0, res.weekday_out, res.hundredths_out, res.second_out,
                       res.minute_out, res.hour_out, res.day_out, res.month_out,
                       res.year_out, res.micro_out, res.seconds_out};

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |-> (!out_valid_r || out_tready))
    else $error("result loaded over one not yet taken");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("rejected conversion carries non-zero fields");

endmodule

`default_nettype wire

[sim/tod_calendar_converter_test.sv]
// Self-checking testbench for the calendar converter: directed and random transactions.
`default_nettype none

module tod_calendar_converter_test;

  localparam logic FUNC_TO_SECS   = 1'b0;
  localparam logic FUNC_TO_FIELDS = 1'b1;

  localparam longint unsigned SECS_PER_DAY = 86400;
  localparam longint unsigned SECS_LIMIT   = 2147483647;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 550;
  localparam int HOLD_CYCLES   = 800;
  localparam int DRAIN_CYCLES  = 320;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum int {
    BRK_YEAR, BRK_MONTH, BRK_DAY, BRK_HOUR, BRK_MINUTE, BRK_SECOND, BRK_HUNDREDTHS,
    BRK_WEEKDAY
  } broken_field_e;

  typedef struct packed {
    logic              func;
    tcc_pkg::in_item_t item;
    logic              typed;
    tcc_pkg::res_t     want;
  } vector_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         out_tuser;

  tcc_pkg::res_t pending_q[$];
  vector_t       directed[$];
  int            mismatches   = 0;
  int            result_count = 0;
  int            cycle_count  = 0;
  int            send_idle;
  int            recv_idle;
  logic          hold_req;

  tod_calendar_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned year_length(input int unsigned yr);
    return ((yr % 4) == 0) ? 366 * SECS_PER_DAY : 365 * SECS_PER_DAY;
  endfunction

  function automatic longint unsigned month_length(input int unsigned mon,
                                                   input int unsigned yr);
    int unsigned days;
    case (mon)
      2:             days = ((yr % 4) == 0) ? 29 : 28;
      4, 6, 9, 11:   days = 30;
      default:       days = 31;
    endcase
    return days * SECS_PER_DAY;
  endfunction

  // Expected result of one conversion in either direction.
  function automatic tcc_pkg::res_t predict_calendar(input logic func,
                                                     input tcc_pkg::in_item_t it);
    tcc_pkg::res_t   r;
    longint unsigned total;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     days;
    int unsigned     hs;
    logic            ok;
    r = '0;
    if (func == FUNC_TO_SECS) begin
      ok = it.month_in >= 1 && it.month_in <= 12 && it.day_in >= 1 && it.day_in <= 31 &&
           it.weekday_in <= 6 && it.hour_in <= 23 && it.minute_in <= 59 &&
           it.second_in <= 59 && it.hundredths_in <= 99 &&
           it.chip_year >= tcc_pkg::YEAR_OFFSET;
      if (ok) begin
        total = 0;
        for (yr = tcc_pkg::YEAR_OFFSET; yr < it.chip_year; yr++) total += year_length(yr);
        for (mon = 1; mon < it.month_in; mon++) total += month_length(mon, it.chip_year);
        total += (longint'(it.day_in) - 1) * SECS_PER_DAY;
        total += longint'(it.hour_in) * 3600 + longint'(it.minute_in) * 60 + it.second_in;
        if (total <= SECS_LIMIT) begin
          r.valid_res   = 1'b1;
          r.seconds_out = total[30:0];
          r.micro_out   = 20'(it.hundredths_in * 10000);
        end
      end
    end else begin
      total = it.epoch_seconds;
      yr    = tcc_pkg::YEAR_OFFSET;
      mon   = 1;
      while (total >= year_length(yr)) begin
        total -= year_length(yr);
        yr++;
      end
      while (mon < 12 && total >= month_length(mon, yr)) begin
        total -= month_length(mon, yr);
        mon++;
      end
      hs               = it.microseconds / 10000;
      r.valid_res      = 1'b1;
      r.hundredths_out = (hs > 99) ? 7'd99 : 7'(hs);
      r.second_out     = 6'(total % 60);
      total            = total / 60;
      r.minute_out     = 6'(total % 60);
      total            = total / 60;
      r.hour_out       = 5'(total % 24);
      days             = int'(total / 24) + 1;
      r.year_out       = yr[7:0];
      r.month_out      = mon[3:0];
      r.day_out        = days[4:0];
      r.weekday_out    = 3'(days % 7);
    end
    return r;
  endfunction

  function automatic logic [119:0] pack_item(input tcc_pkg::in_item_t it);
    return {6'b0, it.microseconds, it.epoch_seconds, it.weekday_in, it.hundredths_in,
            it.second_in, it.minute_in, it.hour_in, it.day_in, it.month_in, it.chip_year};
  endfunction

  function automatic tcc_pkg::in_item_t cal_fields(input int cy, input int mon,
                                                   input int day, input int hr,
                                                   input int mi, input int se,
                                                   input int hs, input int wd);
    tcc_pkg::in_item_t it;
    it               = '0;
    it.chip_year     = 8'(cy);
    it.month_in      = 8'(mon);
    it.day_in        = 8'(day);
    it.hour_in       = 8'(hr);
    it.minute_in     = 8'(mi);
    it.second_in     = 8'(se);
    it.hundredths_in = 7'(hs);
    it.weekday_in    = 8'(wd);
    return it;
  endfunction

  function automatic tcc_pkg::in_item_t epoch_fields(input logic [30:0] es,
                                                     input logic [19:0] us);
    tcc_pkg::in_item_t it;
    it               = '0;
    it.epoch_seconds = es;
    it.microseconds  = us;
    return it;
  endfunction

  // Random item: mostly well-formed calendars and arbitrary epoch values, with a share of
  // single broken fields and pure noise.
  task automatic random_item(output logic func, output tcc_pkg::in_item_t it);
    int kind;
    kind                = $urandom_range(99);
    it.chip_year        = 8'($urandom_range(2, 30));
    it.month_in         = 8'($urandom_range(1, 12));
    it.day_in           = 8'($urandom_range(1, 31));
    it.hour_in          = 8'($urandom_range(0, 23));
    it.minute_in        = 8'($urandom_range(0, 59));
    it.second_in        = 8'($urandom_range(0, 59));
    it.hundredths_in    = 7'($urandom_range(0, 99));
    it.weekday_in       = 8'($urandom_range(0, 6));
    it.epoch_seconds    = 31'($urandom);
    it.microseconds     = 20'($urandom);
    func                = FUNC_TO_SECS;
    if ($urandom_range(7) == 0) it.chip_year = 8'($urandom_range(60, 80));
    if (kind < 45) begin
      // Well-formed calendar, kept as it is.
    end else if (kind < 55) begin
      case (broken_field_e'($urandom_range(0, 7)))
        BRK_YEAR:       it.chip_year = 8'($urandom_range(0, 1));
        BRK_MONTH:      it.month_in = $urandom_range(1) ? 8'd0 : 8'($urandom_range(13, 255));
        BRK_DAY:        it.day_in = $urandom_range(1) ? 8'd0 : 8'($urandom_range(32, 255));
        BRK_HOUR:       it.hour_in = 8'($urandom_range(24, 255));
        BRK_MINUTE:     it.minute_in = 8'($urandom_range(60, 255));
        BRK_SECOND:     it.second_in = 8'($urandom_range(60, 255));
        BRK_HUNDREDTHS: it.hundredths_in = 7'($urandom_range(100, 127));
        default:        it.weekday_in = 8'($urandom_range(7, 255));
      endcase
    end else if (kind < 65) begin
      it.chip_year     = 8'($urandom);
      it.month_in      = 8'($urandom);
      it.day_in        = 8'($urandom);
      it.hour_in       = 8'($urandom);
      it.minute_in     = 8'($urandom);
      it.second_in     = 8'($urandom);
      it.hundredths_in = 7'($urandom);
      it.weekday_in    = 8'($urandom);
    end else begin
      func             = FUNC_TO_FIELDS;
      it.chip_year     = 8'($urandom);
      it.month_in      = 8'($urandom);
      it.day_in        = 8'($urandom);
      it.hour_in       = 8'($urandom);
      it.minute_in     = 8'($urandom);
      it.second_in     = 8'($urandom);
      it.hundredths_in = 7'($urandom);
      it.weekday_in    = 8'($urandom);
      if ($urandom_range(1)) it.epoch_seconds = 31'($urandom_range(0, 200000000));
    end
  endtask

  task automatic send_item(input logic func, input tcc_pkg::in_item_t it, input logic typed,
                           input tcc_pkg::res_t want);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= pack_item(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(typed ? want : predict_calendar(func, it));
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Result checker: every result transaction against the oldest expectation.
  always @(posedge clk) begin
    tcc_pkg::res_t got;
    tcc_pkg::res_t want;
    logic          pad;
    if (rst_n && out_tvalid && out_tready) begin
      got.valid_res = out_tuser;
      {pad, got.weekday_out, got.hundredths_out, got.second_out, got.minute_out,
       got.hour_out, got.day_out, got.month_out, got.year_out, got.micro_out,
       got.seconds_out} = out_tdata;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_q.pop_front();
        check_field("valid_res", got.valid_res, want.valid_res);
        check_field("seconds_out", got.seconds_out, want.seconds_out);
        check_field("micro_out", got.micro_out, want.micro_out);
        check_field("year_out", got.year_out, want.year_out);
        check_field("month_out", got.month_out, want.month_out);
        check_field("day_out", got.day_out, want.day_out);
        check_field("hour_out", got.hour_out, want.hour_out);
        check_field("minute_out", got.minute_out, want.minute_out);
        check_field("second_out", got.second_out, want.second_out);
        check_field("hundredths_out", got.hundredths_out, want.hundredths_out);
        check_field("weekday_out", got.weekday_out, want.weekday_out);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so that the
  // output register fills and the input stalls.
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int                i;
    logic              func;
    tcc_pkg::in_item_t it;
    in_tvalid    = 1'b0;
    in_tuser     = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    send_idle    = 24;
    recv_idle    = 48;
    hold_req     = 1'b0;

    // Minimal calendar, then each range check failing on its own.
    directed.push_back('{FUNC_TO_SECS, cal_fields(2, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                         tcc_pkg::res_t'{valid_res: 1'b1, default: '0}});
    directed.push_back('{FUNC_TO_SECS, cal_fields(1, 1, 1, 0, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(0, 6, 15, 12, 30, 30, 50, 3), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 0, 1, 0, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 13, 1, 0, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 32, 0, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 9, 24, 0, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 9, 0, 60, 0, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 9, 0, 0, 60, 0, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 9, 0, 0, 0, 100, 0), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(10, 5, 9, 0, 0, 0, 0, 7), 1'b1, '0});
    // Largest sum that fits, one second beyond it, and the largest calendar.
    directed.push_back('{FUNC_TO_SECS, cal_fields(70, 1, 19, 3, 14, 7, 99, 6), 1'b1,
                         tcc_pkg::res_t'{valid_res: 1'b1, seconds_out: 31'h7fffffff,
                                         micro_out: 20'd990000, default: '0}});
    directed.push_back('{FUNC_TO_SECS, cal_fields(70, 1, 19, 3, 14, 8, 99, 6), 1'b1, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(255, 12, 31, 23, 59, 59, 99, 6), 1'b1, '0});
    // Leap February, and a day count not checked against the month.
    directed.push_back('{FUNC_TO_SECS, cal_fields(4, 2, 29, 23, 59, 59, 1, 2), 1'b0, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(4, 3, 1, 0, 0, 0, 0, 4), 1'b0, '0});
    directed.push_back('{FUNC_TO_SECS, cal_fields(3, 2, 31, 1, 2, 3, 4, 5), 1'b0, '0});
    // Seconds to fields: the epoch itself, year boundaries and hundredths saturation.
    directed.push_back('{FUNC_TO_FIELDS, epoch_fields(31'd0, 20'd0), 1'b1,
                         tcc_pkg::res_t'{valid_res: 1'b1, year_out: 8'd2, month_out: 4'd1,
                                         day_out: 5'd1, weekday_out: 3'd1, default: '0}});
    directed.push_back('{FUNC_TO_FIELDS, epoch_fields(31'd31535999, 20'd989999), 1'b0, '0});
    directed.push_back('{FUNC_TO_FIELDS, epoch_fields(31'd31536000, 20'd990000), 1'b0, '0});
    directed.push_back('{FUNC_TO_FIELDS, epoch_fields(31'd68169600, 20'd999999), 1'b0, '0});
    directed.push_back('{FUNC_TO_FIELDS, epoch_fields(31'h7fffffff, 20'hfffff), 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k])
      send_item(directed[k].func, directed[k].item, directed[k].typed, directed[k].want);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle = 48;
        recv_idle = 24;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
      end
      random_item(func, it);
      send_item(func, it, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
